// File: rtl/core/fbdraw_pkg.sv
// ----------------------------------------------------------------------------
// fbdraw_pkg
// Shared types, command codes and helpers for the framebuffer draw engine.
// ----------------------------------------------------------------------------
package fbdraw_pkg;

    typedef enum logic [2:0] {
        CMD_FILL  = 3'd0,
        CMD_SET   = 3'd1,
        CMD_GET   = 3'd2,
        CMD_BLEND = 3'd3,
        CMD_RRECT = 3'd4
    } cmd_t;

    typedef enum logic [2:0] {
        REG_SCREEN_W = 3'd0,
        REG_SCREEN_H = 3'd1,
        REG_PITCH    = 3'd2,
        REG_RED_SH   = 3'd3,
        REG_GREEN_SH = 3'd4,
        REG_BLUE_SH  = 3'd5
    } reg_idx_t;

    // One queued job: a clipped rectangle walk, a single pixel write or read.
    typedef struct packed {
        logic        is_get;
        logic        is_blend;
        logic        is_round;
        logic        on_scr;
        logic [11:0] x;
        logic [11:0] y;
        logic [11:0] cols;
        logic [11:0] rows;
        logic [11:0] w;
        logic [11:0] h;
        logic [11:0] rad;
        logic [7:0]  red;
        logic [7:0]  green;
        logic [7:0]  blue;
        logic [7:0]  alpha;
        logic [31:0] colour;
    } job_t;

    typedef enum logic [2:0] {
        BK_IDLE,
        BK_CLEAR,
        BK_WALK,
        BK_READ,
        BK_MIX,
        BK_WRITE,
        BK_OUT
    } bk_state_t;

    function automatic logic [7:0] chan_at(input logic [31:0] p, input logic [4:0] sh);
        logic [31:0] t;
        t = p >> sh;
        return t[7:0];
    endfunction

    // v in 0..65025; result v/255 via reciprocal and one correction
    function automatic logic [7:0] div255(input logic [15:0] v);
        logic [16:0] q;
        logic [16:0] r;
        q = {1'b0, v} >> 8;
        q = ({1'b0, v} + q + 17'd1) >> 8;
        r = q;
        return r[7:0];
    endfunction

endpackage

// File: rtl/core/fbdraw_front.sv
// ----------------------------------------------------------------------------
// fbdraw_front
// Accept commands, clip against the screen and push jobs into a small queue.
// ----------------------------------------------------------------------------
module fbdraw_front (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic [2:0]        cmd,
    input  logic [11:0]       pos_x,
    input  logic [11:0]       pos_y,
    input  logic [11:0]       rect_width,
    input  logic [11:0]       rect_height,
    input  logic [11:0]       corner_radius,
    input  logic [7:0]        red_in,
    input  logic [7:0]        green_in,
    input  logic [7:0]        blue_in,
    input  logic [7:0]        alpha_in,
    input  logic [31:0]       raw_colour,
    input  logic [12:0]       vis_w,
    input  logic [12:0]       vis_h,
    output fbdraw_pkg::job_t  job,
    output logic              job_valid,
    input  logic              job_ready
);

    localparam int Depth = 2;

    fbdraw_pkg::job_t q_reg [Depth];
    logic [0:0] wp_reg, rp_reg;
    logic [1:0] cnt_reg;
    fbdraw_pkg::job_t j;
    logic keep;
    logic push, pop;
    logic [11:0] hw, hh, rd;
    logic [12:0] rem_x, rem_y;

    always_comb
    begin
        j = '0;
        keep = 1'b0;
        rem_x = vis_w - {1'b0, pos_x};
        rem_y = vis_h - {1'b0, pos_y};
        hw = rect_width >> 1;
        hh = rect_height >> 1;
        rd = corner_radius;
        if (rd > hw)
            rd = hw;
        if (rd > hh)
            rd = hh;
        j.on_scr = ({1'b0, pos_x} < vis_w) && ({1'b0, pos_y} < vis_h);
        j.x = pos_x;
        j.y = pos_y;
        j.w = rect_width;
        j.h = rect_height;
        j.rad = rd;
        j.red = red_in;
        j.green = green_in;
        j.blue = blue_in;
        j.alpha = alpha_in;
        j.colour = raw_colour;
        j.cols = ({1'b0, rect_width} < rem_x) ? rect_width : rem_x[11:0];
        j.rows = ({1'b0, rect_height} < rem_y) ? rect_height : rem_y[11:0];
        unique case (cmd)
            fbdraw_pkg::CMD_FILL:
                keep = j.on_scr && rect_width != 12'd0 && rect_height != 12'd0;
            fbdraw_pkg::CMD_SET:
            begin
                keep = j.on_scr;
                j.cols = 12'd1;
                j.rows = 12'd1;
            end
            fbdraw_pkg::CMD_GET:
            begin
                keep = 1'b1;
                j.is_get = 1'b1;
            end
            fbdraw_pkg::CMD_BLEND:
            begin
                keep = j.on_scr && alpha_in != 8'd0;
                j.is_blend = 1'b1;
                j.cols = 12'd1;
                j.rows = 12'd1;
            end
            fbdraw_pkg::CMD_RRECT:
            begin
                keep = j.on_scr && alpha_in != 8'd0 && rect_width != 12'd0
                    && rect_height != 12'd0;
                j.is_blend = 1'b1;
                j.is_round = 1'b1;
            end
            default: keep = 1'b0;
        endcase
    end

    assign in_ready = (cnt_reg != 2'(Depth));
    assign push = in_valid && in_ready && keep;
    assign job_valid = (cnt_reg != 2'd0);
    assign pop = job_valid && job_ready;
    assign job = q_reg[rp_reg];

    always_ff @(posedge clk)
    begin
        if (push)
            q_reg[wp_reg] <= j;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg <= '0;
            rp_reg <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            if (push)
                wp_reg <= wp_reg + 1'b1;
            if (pop)
                rp_reg <= rp_reg + 1'b1;
            cnt_reg <= cnt_reg + 2'(push) - 2'(pop);
        end
    end

    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= 2'(Depth))
        else $error("queue count overflow");
    a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg == 2'(Depth) |-> !push)
        else $error("push into full queue");
    a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> cnt_reg != 2'd0)
        else $error("pop from empty queue");

endmodule

// File: rtl/core/fbdraw_back.sv
// ----------------------------------------------------------------------------
// fbdraw_back
// Clear the store after reset, then walk jobs pixel by pixel over the store.
// ----------------------------------------------------------------------------
module fbdraw_back #(
    parameter int AW = 16
) (
    input  logic              clk,
    input  logic              rst_n,
    input  fbdraw_pkg::job_t  job,
    input  logic              job_valid,
    output logic              job_ready,
    input  logic [8:0]        pitch,
    input  logic [4:0]        red_sh,
    input  logic [4:0]        green_sh,
    input  logic [4:0]        blue_sh,
    output logic              out_valid,
    input  logic              out_ready,
    output logic [31:0]       pixel_value
);

    localparam int Depth = 1 << AW;

    logic [31:0] mem [Depth];

    fbdraw_pkg::bk_state_t st_reg, st_next;
    fbdraw_pkg::job_t j_reg;
    logic [AW:0]   clr_reg;
    logic [11:0]   col_reg, row_reg;
    logic [AW-1:0] addr_reg;
    logic [31:0]   rd_reg;
    logic [31:0]   wd_reg;
    logic          cov;
    logic [12:0]   dx, dy;
    logic [25:0]   d2;
    logic [23:0]   r2;
    logic [11:0]   wr, hr;
    logic          last_col, last_row;
    logic [AW-1:0] row_base;
    logic [23:0]   prod;
    logic [31:0]   pk;
    logic [7:0]    o_r, o_g, o_b, m_r, m_g, m_b;
    logic [7:0]    na;

    assign wr = j_reg.w - j_reg.rad;
    assign hr = j_reg.h - j_reg.rad;
    assign dx = (col_reg < j_reg.rad) ? 13'(j_reg.rad - col_reg)
        : (col_reg >= wr) ? 13'(col_reg - wr + 12'd1) : 13'd0;
    assign dy = (row_reg < j_reg.rad) ? 13'(j_reg.rad - row_reg)
        : (row_reg >= hr) ? 13'(row_reg - hr + 12'd1) : 13'd0;
    assign d2 = 26'(dx) * 26'(dx) + 26'(dy) * 26'(dy);
    assign r2 = 24'(j_reg.rad) * 24'(j_reg.rad);
    assign cov = !j_reg.is_round || (d2 <= 26'(r2));
    assign last_col = (col_reg + 12'd1 == j_reg.cols);
    assign last_row = (row_reg + 12'd1 == j_reg.rows);

    assign prod = (24'(j_reg.y) + 24'(row_reg)) * 24'(pitch);
    assign row_base = AW'(prod);

    assign na = 8'd255 - j_reg.alpha;
    assign o_r = fbdraw_pkg::chan_at(rd_reg, red_sh);
    assign o_g = fbdraw_pkg::chan_at(rd_reg, green_sh);
    assign o_b = fbdraw_pkg::chan_at(rd_reg, blue_sh);
    assign m_r = fbdraw_pkg::div255(16'(j_reg.red) * 16'(j_reg.alpha)
        + 16'(o_r) * 16'(na));
    assign m_g = fbdraw_pkg::div255(16'(j_reg.green) * 16'(j_reg.alpha)
        + 16'(o_g) * 16'(na));
    assign m_b = fbdraw_pkg::div255(16'(j_reg.blue) * 16'(j_reg.alpha)
        + 16'(o_b) * 16'(na));
    assign pk = (j_reg.alpha == 8'd255)
        ? ((32'(j_reg.red) << red_sh) | (32'(j_reg.green) << green_sh)
            | (32'(j_reg.blue) << blue_sh))
        : ((32'(m_r) << red_sh) | (32'(m_g) << green_sh) | (32'(m_b) << blue_sh));

    always_comb
    begin
        st_next = st_reg;
        unique case (st_reg)
            fbdraw_pkg::BK_CLEAR:
                if (clr_reg == (AW+1)'(Depth - 1))
                    st_next = fbdraw_pkg::BK_IDLE;
            fbdraw_pkg::BK_IDLE:
                if (job_valid)
                    st_next = fbdraw_pkg::BK_WALK;
            fbdraw_pkg::BK_WALK:
                if (j_reg.is_get || (j_reg.is_blend && cov))
                    st_next = fbdraw_pkg::BK_READ;
                else if (last_col && last_row)
                    st_next = fbdraw_pkg::BK_IDLE;
            fbdraw_pkg::BK_READ:
                st_next = j_reg.is_get ? fbdraw_pkg::BK_OUT : fbdraw_pkg::BK_MIX;
            fbdraw_pkg::BK_MIX:
                st_next = fbdraw_pkg::BK_WRITE;
            fbdraw_pkg::BK_WRITE:
                st_next = (last_col && last_row) ? fbdraw_pkg::BK_IDLE
                    : fbdraw_pkg::BK_WALK;
            fbdraw_pkg::BK_OUT:
                if (out_ready)
                    st_next = fbdraw_pkg::BK_IDLE;
            default: st_next = fbdraw_pkg::BK_IDLE;
        endcase
    end

    always_comb
    begin
        job_ready = (st_reg == fbdraw_pkg::BK_IDLE);
        out_valid = (st_reg == fbdraw_pkg::BK_OUT);
        pixel_value = j_reg.on_scr ? rd_reg : 32'd0;
    end

    // store port: clear, fill and blend writes; read of the address registered in WALK
    always_ff @(posedge clk)
    begin
        if (st_reg == fbdraw_pkg::BK_CLEAR)
            mem[clr_reg[AW-1:0]] <= '0;
        else if (st_reg == fbdraw_pkg::BK_WALK && !j_reg.is_get && !j_reg.is_blend)
            mem[AW'(row_base + AW'(j_reg.x + col_reg))] <= j_reg.colour;
        else if (st_reg == fbdraw_pkg::BK_WRITE)
            mem[addr_reg] <= wd_reg;
        rd_reg <= mem[addr_reg];
        if (st_reg == fbdraw_pkg::BK_MIX)
            wd_reg <= pk;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg <= fbdraw_pkg::BK_CLEAR;
            clr_reg <= '0;
            col_reg <= '0;
            row_reg <= '0;
            j_reg <= '0;
            addr_reg <= '0;
        end
        else
        begin
            st_reg <= st_next;
            if (st_reg == fbdraw_pkg::BK_CLEAR)
                clr_reg <= clr_reg + 1'b1;
            if (st_reg == fbdraw_pkg::BK_IDLE && job_valid)
            begin
                j_reg <= job;
                col_reg <= '0;
                row_reg <= '0;
            end
            if (st_reg == fbdraw_pkg::BK_WALK)
                addr_reg <= AW'(row_base + AW'(j_reg.x + col_reg));
            if ((st_reg == fbdraw_pkg::BK_WALK && st_next != fbdraw_pkg::BK_READ)
                || st_reg == fbdraw_pkg::BK_WRITE)
            begin
                if (last_col)
                begin
                    col_reg <= '0;
                    row_reg <= row_reg + 12'd1;
                end
                else
                    col_reg <= col_reg + 12'd1;
            end
        end
    end

    a_get_out: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> j_reg.is_get)
        else $error("result without read command");
    a_hold_out: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(pixel_value))
        else $error("result dropped");
    a_clear_block: assert property (@(posedge clk) disable iff (!rst_n)
        st_reg == fbdraw_pkg::BK_CLEAR |-> !job_ready)
        else $error("job taken during clear");

endmodule

// File: rtl/core/framebuffer_draw_blend_engine.sv
// ----------------------------------------------------------------------------
// framebuffer_draw_blend_engine
// 2D fill, pixel access and alpha blend over a local 32-bit framebuffer.
// ----------------------------------------------------------------------------
//  channel   signals                        transaction
//  in        in_valid / in_ready            one command
//  out       out_valid / out_ready          pixel_value of a get_pixel
//  cfg       cfg_we / cfg_index / cfg_data  one register write
// After reset the store is cleared word by word; the walker takes no job then.
// fill and set write one pixel a cycle; a covered blend pixel steps through walk,
// read, mix and write (the single store port), an uncovered one is skipped in walk.
// get_pixel passes walk and read, then holds its result until out_ready.
// A two-entry queue between decode and the store walker lets input run ahead.
// ----------------------------------------------------------------------------
module framebuffer_draw_blend_engine #(
    parameter int MAX_WIDTH   = 256,
    parameter int MAX_HEIGHT  = 256,
    parameter int STORE_DEPTH = 65536
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [2:0]  cmd,
    input  logic [11:0] pos_x,
    input  logic [11:0] pos_y,
    input  logic [11:0] rect_width,
    input  logic [11:0] rect_height,
    input  logic [11:0] corner_radius,
    input  logic [7:0]  red_in,
    input  logic [7:0]  green_in,
    input  logic [7:0]  blue_in,
    input  logic [7:0]  alpha_in,
    input  logic [31:0] raw_colour,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [31:0] pixel_value,
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [8:0]  cfg_data
);

    localparam int AW = $clog2(STORE_DEPTH);

    logic [8:0] sw_reg, sh_reg, pitch_reg;
    logic [4:0] rsh_reg, gsh_reg, bsh_reg;
    logic [12:0] vis_w, vis_h;
    fbdraw_pkg::job_t job;
    logic job_valid, job_ready;

    assign vis_w = (13'(sw_reg) < 13'(MAX_WIDTH)) ? 13'(sw_reg) : 13'(MAX_WIDTH);
    assign vis_h = (13'(sh_reg) < 13'(MAX_HEIGHT)) ? 13'(sh_reg) : 13'(MAX_HEIGHT);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sw_reg <= 9'd256;
            sh_reg <= 9'd256;
            pitch_reg <= 9'd256;
            rsh_reg <= 5'd16;
            gsh_reg <= 5'd8;
            bsh_reg <= 5'd0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                fbdraw_pkg::REG_SCREEN_W: sw_reg <= cfg_data;
                fbdraw_pkg::REG_SCREEN_H: sh_reg <= cfg_data;
                fbdraw_pkg::REG_PITCH:    pitch_reg <= cfg_data;
                fbdraw_pkg::REG_RED_SH:   rsh_reg <= cfg_data[4:0];
                fbdraw_pkg::REG_GREEN_SH: gsh_reg <= cfg_data[4:0];
                fbdraw_pkg::REG_BLUE_SH:  bsh_reg <= cfg_data[4:0];
                default: ;
            endcase
        end
    end

    fbdraw_front u_front (
        .clk, .rst_n, .in_valid, .in_ready, .cmd, .pos_x, .pos_y, .rect_width,
        .rect_height, .corner_radius, .red_in, .green_in, .blue_in, .alpha_in,
        .raw_colour, .vis_w, .vis_h, .job, .job_valid, .job_ready
    );

    fbdraw_back #(.AW(AW)) u_back (
        .clk, .rst_n, .job, .job_valid, .job_ready, .pitch(pitch_reg),
        .red_sh(rsh_reg), .green_sh(gsh_reg), .blue_sh(bsh_reg),
        .out_valid, .out_ready, .pixel_value
    );

endmodule
